@@ src/wrs_pkg.sv @@
// Shared types and constants for the weighted roulette selector.
// Used by wrs_cell, weighted_roulette_selector and the testbench; depends on nothing else.
package wrs_pkg;

  // Table depth and fixed-point format of the weights (Q1.FRAC_BITS).
  localparam int MAX_ENTRIES = 8;
  localparam int FRAC_BITS   = 16;

  localparam int IDX_W     = $clog2(MAX_ENTRIES);
  localparam int WEIGHT_W  = FRAC_BITS + 1;
  localparam int FRAC_W    = FRAC_BITS;
  // Wide enough for MAX_ENTRIES weights at full scale.
  localparam int TOTAL_W   = WEIGHT_W + IDX_W;
  localparam int COUNT_W   = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = WEIGHT_W;

  localparam logic [TOTAL_W-1:0] ONE_VALUE = TOTAL_W'(1) << FRAC_BITS;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_DRAW = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENTRY_COUNT  = 2'd0,
    CFG_CORRECT_LAST = 2'd1,
    CFG_TOLERANCE    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SUM    = 4'b0010,
    ST_MUL    = 4'b0100,
    ST_SEARCH = 4'b1000
  } state_e;

  typedef struct packed {
    logic                operation;
    logic [IDX_W-1:0]    entry_index;
    logic [WEIGHT_W-1:0] weight;
    logic [FRAC_W-1:0]   random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] selected_index;
    logic               fell_through;
  } out_item_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic                load;
    logic                active;
    logic [WEIGHT_W-1:0] weight;
  } cell_ctrl_t;

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic [TOTAL_W-1:0] cum;
    logic               found;
  } cell_link_t;

endpackage

@@ src/wrs_cell.sv @@
// One cell of the selector chain: holds one weight entry and its running sum.
// Depends on wrs_pkg.
module wrs_cell
  import wrs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_ctrl_t         ctrl_i,
  input  cell_link_t         link_i,
  input  logic [TOTAL_W-1:0] point_i,
  output cell_link_t         link_o,
  output logic               hit_o
);

  logic [WEIGHT_W-1:0] weight_q;
  logic [TOTAL_W-1:0]  cum_q, cum_d;
  logic                below;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      weight_q <= ctrl_i.weight;
    end
  end

  // The cumulative sum ripples one cell per cycle; entries past the count add nothing.
  assign cum_d = link_i.cum + (ctrl_i.active ? TOTAL_W'(weight_q) : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cum_q <= '0;
    end else begin
      cum_q <= cum_d;
    end
  end

  // This cell's interval ends at cum_q; the first cell whose end lies above the point wins.
  assign below       = point_i < cum_q;
  assign hit_o       = below && !link_i.found;
  assign link_o.cum   = cum_q;
  assign link_o.found = link_i.found || below;

endmodule

@@ src/weighted_roulette_selector.sv @@
// Top level of the weighted roulette selector: sequencer, configuration and cell chain.
// Depends on wrs_pkg and wrs_cell.
//
// A load item writes one weight into its cell and leaves the sequencer idle. A draw item's
// result is offered once the running sums have rippled through the chain of MAX_ENTRIES
// cells one cell per cycle in the summing state, the multiply state has scaled the fraction
// by the total with a single multiply, and the search state has compared the point in
// every cell and registered the result. A new item is taken only while no draw is at work,
// so the next item is not accepted before the result is offered. A finished result waits in
// the output register and does not block loads or the next draw from starting; a second
// draw whose result finds the register still occupied waits in its last cycle and holds
// off the input.
module weighted_roulette_selector
  import wrs_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_item_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_item_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;
  logic [COUNT_W-1:0]  entry_count_q;
  logic                correct_last_q;
  logic [WEIGHT_W-1:0] tolerance_q;
  logic [IDX_W-1:0]    cnt_q, cnt_d;
  logic [FRAC_W-1:0]   frac_q;
  logic [TOTAL_W-1:0]  point_q, point_d;
  logic                append_q, append_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic               in_accept;
  logic               out_load;
  logic [COUNT_W-1:0] used_n;
  logic [TOTAL_W-1:0] total, diff;
  logic               over_one;
  logic [FRAC_W+TOTAL_W-1:0] product;
  logic [IDX_W-1:0]   hit_idx;
  logic               any_hit;

  cell_ctrl_t  ctrl  [MAX_ENTRIES];
  cell_link_t  link  [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] hit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q  <= COUNT_W'(1);
      correct_last_q <= 1'b1;
      tolerance_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ENTRY_COUNT:  entry_count_q  <= cfg_data_i[COUNT_W-1:0];
        CFG_CORRECT_LAST: correct_last_q <= cfg_data_i[0];
        CFG_TOLERANCE:    tolerance_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Entries in use: zero counts as one, larger values saturate at the table depth.
  always_comb begin
    if (entry_count_q == '0) begin
      used_n = COUNT_W'(1);
    end else if (entry_count_q > COUNT_W'(MAX_ENTRIES)) begin
      used_n = COUNT_W'(MAX_ENTRIES);
    end else begin
      used_n = entry_count_q;
    end
  end

  // Cell chain.
  assign link[0].cum   = '0;
  assign link[0].found = 1'b0;

  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    assign ctrl[k].load   = in_accept && (in_data_i.operation == OP_LOAD) &&
                            (in_data_i.entry_index == IDX_W'(k));
    assign ctrl[k].active = COUNT_W'(k) < used_n;
    assign ctrl[k].weight = in_data_i.weight;

    wrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl[k]),
      .link_i  (link[k]),
      .point_i (point_q),
      .link_o  (link[k+1]),
      .hit_o   (hit[k])
    );
  end

  // Scaling and remainder decision, used in the multiply cycle.
  assign total    = link[MAX_ENTRIES].cum;
  assign over_one = total > ONE_VALUE;
  assign diff     = over_one ? (total - ONE_VALUE) : (ONE_VALUE - total);
  assign product  = frac_q * total;

  always_comb begin
    hit_idx = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      if (hit[k]) begin
        hit_idx = hit_idx | IDX_W'(k);
      end
    end
  end
  assign any_hit = |hit;

  assign out_load = (state_q == ST_SEARCH) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    point_d     = point_q;
    append_d    = append_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_accept && (in_data_i.operation == OP_DRAW)) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(MAX_ENTRIES - 1)) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        point_d  = over_one ? product[FRAC_BITS +: TOTAL_W] : TOTAL_W'(frac_q);
        append_d = correct_last_q && !over_one && (diff > TOTAL_W'(tolerance_q));
        state_d  = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          if (any_hit) begin
            out_d.selected_index = COUNT_W'(hit_idx);
            out_d.fell_through   = 1'b0;
          end else if (append_q) begin
            // The remainder entry ends at one and always holds the point.
            out_d.selected_index = used_n;
            out_d.fell_through   = 1'b0;
          end else begin
            out_d.selected_index = used_n - COUNT_W'(1);
            out_d.fell_through   = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      frac_q <= in_data_i.random_fraction;
    end
    point_q  <= point_d;
    append_q <= append_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A draw always starts the summing phase in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && (in_data_i.operation == OP_DRAW) |=> state_q == ST_SUM)
    else $error("draw item did not start the summing phase");

  // The found chain lets at most one cell claim the point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH |-> $onehot0(hit))
    else $error("more than one cell claimed the point");

  // A new result only comes out of the search cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_SEARCH)
    else $error("result appeared outside the search cycle");

  // With a remainder entry the point lies below one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEARCH && append_q |-> point_q < ONE_VALUE)
    else $error("point beyond one while a remainder entry is appended");

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for weighted_roulette_selector: loads weight tables, draws selections
// and compares every selection with an in-bench computation of the roulette wheel.
// Depends on wrs_pkg and the weighted_roulette_selector RTL.
`timescale 1ns / 100ps

module testbench;
  import wrs_pkg::*;

  localparam int          LIMIT_CYCLES   = 400_000;
  localparam int          SETTLE_CYCLES  = 2 * (MAX_ENTRIES + 3);
  localparam int          PHASE_ITEMS    = 110;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int unsigned ONE_WEIGHT     = 1 << FRAC_BITS;
  // Register index past the end of the list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_data_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_data_o;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  weighted_roulette_selector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Mirror of the block's table and registers.
  logic [WEIGHT_W-1:0] wheel_weights [MAX_ENTRIES];
  logic [COUNT_W-1:0]  wheel_entry_count = 4'd1;
  logic                wheel_correct_last = 1'b1;
  logic [WEIGHT_W-1:0] wheel_tolerance = '0;

  in_item_t  queued_items[$];
  out_item_t pending_selections[$];
  int        items_queued = 0;
  int        items_accepted = 0;
  int        results_seen = 0;
  int        fail_count = 0;
  int        cycle_count = 0;

  function automatic int unsigned entries_in_use(logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > MAX_ENTRIES) return MAX_ENTRIES;
    return 32'(count);
  endfunction

  function automatic out_item_t expected_selection(logic [FRAC_W-1:0] frac);
    int unsigned     used, span, i;
    longint unsigned total, shortfall, point, lower, width, one_val;
    logic            add_rest;
    out_item_t       pick;
    one_val = ONE_VALUE;
    used = entries_in_use(wheel_entry_count);
    total = 0;
    for (i = 0; i < used; i++) total += wheel_weights[i];
    shortfall = (total > one_val) ? total - one_val : one_val - total;
    add_rest = wheel_correct_last && (shortfall > wheel_tolerance) && (total <= one_val);
    span = add_rest ? used + 1 : used;
    point = (total > one_val) ? (longint'(frac) * total) >> FRAC_BITS : longint'(frac);
    lower = 0;
    for (i = 0; i < span; i++) begin
      width = (i < used) ? longint'(wheel_weights[i]) : shortfall;
      if (lower <= point && point < lower + width) begin
        pick.selected_index = COUNT_W'(i);
        pick.fell_through = 1'b0;
        return pick;
      end
      lower += width;
    end
    pick.selected_index = COUNT_W'(span - 1);
    pick.fell_through = 1'b1;
    return pick;
  endfunction

  task automatic queue_load(int unsigned idx, int unsigned w);
    in_item_t item;
    item.operation = OP_LOAD;
    item.entry_index = IDX_W'(idx);
    item.weight = WEIGHT_W'(w);
    item.random_fraction = FRAC_W'($urandom());
    queued_items = {queued_items, item};
    items_queued++;
  endtask

  task automatic queue_draw(int unsigned frac);
    in_item_t item;
    item.operation = OP_DRAW;
    item.entry_index = IDX_W'($urandom());
    item.weight = WEIGHT_W'($urandom());
    item.random_fraction = FRAC_W'(frac);
    queued_items = {queued_items, item};
    items_queued++;
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    case (idx)
      CFG_ENTRY_COUNT:  wheel_entry_count = COUNT_W'(value);
      CFG_CORRECT_LAST: wheel_correct_last = value[0];
      CFG_TOLERANCE:    wheel_tolerance = WEIGHT_W'(value);
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Registers may only change once the block has drained.
  task automatic settle_idle();
    while (items_accepted != items_queued || pending_selections.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Loads a whole wheel of the given shape into the entries in use, then draws from it.
  task automatic queue_wheel(int unsigned used, int unsigned shape);
    int unsigned cuts[$];
    int unsigned order[$];
    int unsigned shares[MAX_ENTRIES];
    int unsigned budget, shortfall, prefix, i, j;
    int          edge_pt;
    budget = ONE_WEIGHT;
    if (shape == 1) begin
      // Shortfall around the tolerance, so that both sides of the comparison occur.
      case ($urandom_range(0, 3))
        0:       shortfall = wheel_tolerance;
        1:       shortfall = wheel_tolerance + 1;
        2:       shortfall = (wheel_tolerance > 0) ? wheel_tolerance - 1 : 0;
        default: shortfall = $urandom_range(1, ONE_WEIGHT);
      endcase
      if (shortfall > ONE_WEIGHT) shortfall = ONE_WEIGHT;
      budget = ONE_WEIGHT - shortfall;
    end
    if (shape <= 1) begin
      for (i = 0; i + 1 < used; i++) cuts = {cuts, $urandom_range(0, budget)};
      cuts.sort();
      prefix = 0;
      for (i = 0; i + 1 < used; i++) begin
        shares[i] = cuts[i] - prefix;
        prefix = cuts[i];
      end
      shares[used-1] = budget - prefix;
    end else begin
      for (i = 0; i < used; i++) begin
        if (shape == 2) shares[i] = $urandom_range(0, 2 * ONE_WEIGHT - 1);
        else shares[i] = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 8192) : 0;
      end
    end
    for (i = 0; i < used; i++) order = {order, i};
    order.shuffle();
    foreach (order[k]) queue_load(order[k], shares[order[k]]);
    repeat ($urandom_range(1, 10)) begin
      case ($urandom_range(0, 3))
        0: queue_draw($urandom_range(0, 1) ? ONE_WEIGHT - 1 : 0);
        1: begin
          j = $urandom_range(0, used - 1);
          prefix = 0;
          for (i = 0; i <= j; i++) prefix += shares[i];
          edge_pt = int'(prefix) + int'($urandom_range(0, 2)) - 1;
          if (edge_pt < 0) edge_pt = 0;
          if (edge_pt > int'(ONE_WEIGHT) - 1) edge_pt = ONE_WEIGHT - 1;
          queue_draw(edge_pt);
        end
        default: queue_draw($urandom_range(0, ONE_WEIGHT - 1));
      endcase
    end
  endtask

  // Sender: bursts of items separated by random gaps; a stalled item is held as it is.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (in_data_i.operation == OP_LOAD) begin
          wheel_weights[in_data_i.entry_index] = in_data_i.weight;
        end else begin
          pending_selections = {pending_selections,
                                expected_selection(in_data_i.random_fraction)};
        end
        items_accepted++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (queued_items.size() > 0) begin
          in_data_i <= queued_items.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 32);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall rate changes from stretch to stretch, plus one long hold-off that
  // lets the block fill up while the sender keeps offering items.
  int  stall_pct = 0;
  int  pattern_left = 0;
  int  hold_left = 0;
  bit  held_once = 1'b0;
  int  stall_rates[5] = '{0, 0, 30, 70, 95};

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!held_once && results_seen >= 150 && queued_items.size() > 20) begin
        held_once = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        if (pattern_left == 0) begin
          stall_pct = stall_rates[$urandom_range(0, 4)];
          pattern_left = $urandom_range(10, 80);
        end
        pattern_left--;
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  out_item_t oldest_pick;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_selections.size() == 0) begin
        $display("%0t: unexpected selection: expected none, actual index %0d fell_through %0b",
                 $time, out_data_o.selected_index, out_data_o.fell_through);
        fail_count++;
      end else begin
        oldest_pick = pending_selections.pop_front();
        if (out_data_o.selected_index !== oldest_pick.selected_index) begin
          $display("%0t: selected_index mismatch: expected %0d, actual %0d",
                   $time, oldest_pick.selected_index, out_data_o.selected_index);
          fail_count++;
        end
        if (out_data_o.fell_through !== oldest_pick.fell_through) begin
          $display("%0t: fell_through mismatch: expected %0b, actual %0b",
                   $time, oldest_pick.fell_through, out_data_o.fell_through);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[weighted_roulette_selector] ERROR");
    $finish;
  end

  int unsigned entry_counts[10] = '{8, 1, 15, 3, 0, 9, 5, 8, 2, 6};
  int unsigned tol_value, used, p, phase_start;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one entry, correction on, zero tolerance. Every entry is
    // written before any draw so that no unwritten entry is ever read.
    queue_load(0, 16384);
    queue_load(1, 131071);
    queue_load(2, ONE_WEIGHT);
    queue_load(3, 1);
    queue_load(4, 0);
    queue_load(5, 98304);
    queue_load(6, 43690);
    queue_load(7, 21845);
    queue_draw(0);
    queue_draw(16383);
    queue_draw(16384);
    queue_draw(ONE_WEIGHT - 1);
    // A zero weight is skipped and the remainder entry takes the whole wheel.
    queue_load(0, 0);
    queue_draw(0);
    // Total above one: the fraction is scaled by the total.
    queue_load(0, 131071);
    queue_draw(ONE_WEIGHT - 1);
    // Total exactly one: no remainder entry.
    queue_load(0, ONE_WEIGHT);
    queue_draw(ONE_WEIGHT - 1);
    settle_idle();

    // Entry count zero acts as one; with correction off a short wheel falls through.
    write_register(CFG_ENTRY_COUNT, 0);
    write_register(CFG_CORRECT_LAST, 0);
    write_register(CFG_TOLERANCE, 2 * ONE_WEIGHT - 1);
    write_register(CFG_UNUSED_IDX, 2 * ONE_WEIGHT - 1);
    queue_load(0, 0);
    queue_draw(ONE_WEIGHT - 1);
    queue_load(0, 100);
    queue_draw(99);
    queue_draw(100);

    for (p = 0; p < 10; p++) begin
      settle_idle();
      case (p % 5)
        0:       tol_value = 0;
        1:       tol_value = ONE_WEIGHT;
        2:       tol_value = 2 * ONE_WEIGHT - 1;
        3:       tol_value = $urandom_range(0, 64);
        default: tol_value = $urandom_range(0, 16384);
      endcase
      write_register(CFG_ENTRY_COUNT, entry_counts[p]);
      write_register(CFG_CORRECT_LAST, (p % 3 != 1));
      write_register(CFG_TOLERANCE, tol_value);
      used = entries_in_use(COUNT_W'(entry_counts[p]));
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          if ($urandom_range(0, 1)) queue_load($urandom_range(0, 7), $urandom_range(0, 131071));
          else queue_draw($urandom_range(0, ONE_WEIGHT - 1));
        end else begin
          queue_wheel(used, $urandom_range(0, 3));
        end
      end
    end

    settle_idle();
    if (fail_count == 0) begin
      $display("[weighted_roulette_selector] OK");
    end else begin
      $display("[weighted_roulette_selector] ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/wrs_pkg.sv
src/wrs_cell.sv
src/weighted_roulette_selector.sv
tb/sv/testbench.sv
